FILE: design/magic_header_frame_deframer_defines.svh
// Assertion helpers for the frame deframer.
`ifndef MAGIC_HEADER_FRAME_DEFRAMER_DEFINES_SVH
`define MAGIC_HEADER_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MHFD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MHFD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mhfd_pkg.sv
package mhfd_pkg;

  // Fixed field widths of the stream and config ports
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DIM_FIELD_W = 12;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_TDATA_W = BYTE_W + 2 * DIM_FIELD_W;

  // Reset value of both dimension limits
  localparam int unsigned DIM_LIMIT_RESET = 2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_MAGIC = 2'd0,
    REG_MAX_WIDTH   = 2'd1,
    REG_MAX_HEIGHT  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_SLIP    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   last;
    logic [DIM_FIELD_W-1:0] height;
    logic [DIM_FIELD_W-1:0] width;
    logic [BYTE_W-1:0]      data;
  } res_t;

endpackage

FILE: design/magic_header_frame_deframer.sv
// Magic-word frame deframer. One stream byte is taken per beat on s_axis, one
// beat per clock while ready. While hunting, bytes shift into a header window;
// when HEADER_BYTES bytes are in, the first three little-endian words are
// read as magic, width and height. A wrong magic emits a slip event and the
// window slides one byte (the next byte is checked at once). A good magic with
// a zero or over-limit dimension emits a reject event and the header is
// dropped; otherwise an accept event is emitted and the next
// width*height*BYTES_PER_PIXEL bytes pass out as payload events, the final one
// with tlast. Header bytes that only fill the window emit nothing. All work
// for a byte is done in the cycle it is accepted, the longest path being the
// width*height*BYTES_PER_PIXEL product formed on the header's last byte. The
// result lands in an output register backed by a one-entry skid register, so
// while m_axis stalls s_axis keeps taking bytes until a second event beat is
// waiting, when s_axis_tready drops. Config writes take effect at once.
`include "magic_header_frame_deframer_defines.svh"

module magic_header_frame_deframer #(
  parameter int unsigned HEADER_BYTES    = 12,
  parameter int unsigned BYTES_PER_PIXEL = 3,
  parameter int unsigned DIM_BITS        = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [mhfd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mhfd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mhfd_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] in_byte
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] out_byte, [19:8] frame_width, [31:20] frame_height
  output logic [mhfd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,  // [1:0] event_kind
  output logic                                 m_axis_tlast   // last
);
  import mhfd_pkg::*;

  // Limits keep only the bits both the 12-bit field and DIM_BITS allow
  localparam int unsigned LIM_W  = (DIM_BITS < DIM_FIELD_W) ? DIM_BITS : DIM_FIELD_W;
  localparam int unsigned LEFT_W = 2 * LIM_W + 2;
  localparam int unsigned FILL_W = $clog2(HEADER_BYTES);
  localparam int unsigned SR_N   = HEADER_BYTES - 1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HEADER_BYTES - 1);
  localparam logic [LIM_W-1:0]  LIM_RESET = LIM_W'(DIM_LIMIT_RESET);

  // config registers
  logic [CFG_DATA_W-1:0] magic_q;
  logic [LIM_W-1:0]      max_w_q, max_h_q;

  // header hunt / payload state
  logic [BYTE_W-1:0] win_q [SR_N];   // oldest byte at index 0
  logic [FILL_W-1:0] fill_q;
  logic              pay_q;
  logic [LEFT_W-1:0] left_q;
  logic [LIM_W-1:0]  cur_w_q, cur_h_q;

  // output register and skid
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  logic in_acc, pop;
  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  // Full window as it stands with this beat's byte appended
  logic [BYTE_W-1:0] win_full [HEADER_BYTES];
  always_comb begin
    for (int i = 0; i < SR_N; i++) begin
      win_full[i] = win_q[i];
    end
    win_full[HEADER_BYTES-1] = s_axis_tdata;
  end

  logic [31:0] hdr_magic, hdr_w, hdr_h;
  assign hdr_magic = {win_full[3], win_full[2], win_full[1], win_full[0]};
  assign hdr_w     = {win_full[7], win_full[6], win_full[5], win_full[4]};
  assign hdr_h     = {win_full[11], win_full[10], win_full[9], win_full[8]};

  logic w_ok, h_ok, magic_ok, hdr_done;
  assign w_ok = (hdr_w != 32'd0) && (hdr_w[31:LIM_W] == '0) && (hdr_w[LIM_W-1:0] <= max_w_q);
  assign h_ok = (hdr_h != 32'd0) && (hdr_h[31:LIM_W] == '0) && (hdr_h[LIM_W-1:0] <= max_h_q);
  assign magic_ok = (hdr_magic == magic_q);
  assign hdr_done = (fill_q == FILL_FULL);

  logic [LEFT_W-1:0] frame_len;
  assign frame_len = LEFT_W'(hdr_w[LIM_W-1:0]) * LEFT_W'(hdr_h[LIM_W-1:0])
                   * LEFT_W'(BYTES_PER_PIXEL);

  // Per-beat decision
  logic              fin;
  logic              res_valid;
  res_t              res;
  logic [FILL_W-1:0] fill_d;
  logic              pay_d;
  logic [LEFT_W-1:0] left_d;
  logic [LIM_W-1:0]  cur_w_d, cur_h_d;

  assign fin = (left_q <= LEFT_W'(1));

  always_comb begin
    fill_d    = fill_q;
    pay_d     = pay_q;
    left_d    = left_q;
    cur_w_d   = cur_w_q;
    cur_h_d   = cur_h_q;
    res_valid = 1'b0;
    res.kind  = KIND_PAYLOAD;
    res.data  = '0;
    res.last  = 1'b0;
    if (pay_q) begin
      res_valid = 1'b1;
      res.data  = s_axis_tdata;
      res.last  = fin;
      left_d    = (left_q == '0) ? '0 : left_q - LEFT_W'(1);
      if (fin) begin
        pay_d  = 1'b0;
        fill_d = '0;
      end
    end else if (!hdr_done) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (!magic_ok) begin
      // window slides: fill stays at one short of full
      res_valid = 1'b1;
      res.kind  = KIND_SLIP;
    end else begin
      res_valid = 1'b1;
      fill_d    = '0;
      if (w_ok && h_ok) begin
        res.kind = KIND_ACCEPT;
        cur_w_d  = hdr_w[LIM_W-1:0];
        cur_h_d  = hdr_h[LIM_W-1:0];
        left_d   = frame_len;
        pay_d    = 1'b1;
      end else begin
        res.kind = KIND_REJECT;
      end
    end
    res.width  = DIM_FIELD_W'(cur_w_d);
    res.height = DIM_FIELD_W'(cur_h_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q      <= '0;
      max_w_q      <= LIM_RESET;
      max_h_q      <= LIM_RESET;
      fill_q       <= '0;
      pay_q        <= 1'b0;
      left_q       <= '0;
      cur_w_q      <= '0;
      cur_h_q      <= '0;
      out_q        <= '0;
      skid_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_MAGIC: magic_q <= cfg_data_i;
          REG_MAX_WIDTH:   max_w_q <= cfg_data_i[LIM_W-1:0];
          REG_MAX_HEIGHT:  max_h_q <= cfg_data_i[LIM_W-1:0];
          default: ;  // unmapped index: ignored
        endcase
      end
      if (in_acc) begin
        fill_q  <= fill_d;
        pay_q   <= pay_d;
        left_q  <= left_d;
        cur_w_q <= cur_w_d;
        cur_h_q <= cur_h_d;
      end
      // output register with one-entry skid
      if (skid_valid_q) begin
        if (pop) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc && res_valid) begin
        if (!out_valid_q || pop) begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res;
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // header window: plain shift line, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc && !pay_q) begin
      for (int i = 0; i < SR_N - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[SR_N-1] <= s_axis_tdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.height, out_q.width, out_q.data};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // skid only fills behind a held output beat
  `MHFD_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  // a running payload always has bytes left
  `MHFD_ASSERT_NOW(a_pay_has_left, pay_q, left_q != '0, "payload active with zero count")
  // the final payload byte ends the frame
  `MHFD_ASSERT_NEXT(a_last_ends_frame, in_acc && pay_q && (left_q == LEFT_W'(1)), !pay_q,
                    "payload did not end after last byte")

endmodule
